// ===== hdl/vcf_pkg.sv =====
// shared types, constants and speed helpers for the camera command framer
`timescale 1ns / 1ps
package vcf_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int PAY_BYTES   = 9;
  localparam int HDR_BYTES   = 8;
  localparam int MAX_PKT     = 17;
  localparam int PKT_CNT_W   = 5;
  localparam int PAY_LEN_W   = 4;
  localparam int PAY_IDX_W   = 4;

  localparam logic [7:0] BYTE_ADDR   = 8'h81;
  localparam logic [7:0] BYTE_CMD    = 8'h01;
  localparam logic [7:0] BYTE_TERM   = 8'hff;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] CAT_CAMERA  = 8'h04;
  localparam logic [7:0] CAT_PANTILT = 8'h06;
  localparam logic [7:0] FN_DRIVE    = 8'h01;
  localparam logic [7:0] FN_HOME     = 8'h04;
  localparam logic [7:0] FN_ZOOM     = 8'h07;
  localparam logic [7:0] FN_FOCUS    = 8'h08;
  localparam logic [7:0] FN_AF       = 8'h38;
  localparam logic [7:0] FN_PRESET   = 8'h3f;
  localparam logic [7:0] AF_ON       = 8'h02;
  localparam logic [7:0] AF_OFF      = 8'h03;
  localparam logic [7:0] PRE_RECALL  = 8'h02;
  localparam logic [7:0] PRE_STORE   = 8'h01;
  localparam logic [7:0] PRE_CLEAR   = 8'h00;
  localparam logic [7:0] DIR_A       = 8'h01;
  localparam logic [7:0] DIR_B       = 8'h02;
  localparam logic [7:0] DIR_STOP    = 8'h03;
  localparam logic [3:0] LENS_POS    = 4'h2;
  localparam logic [3:0] LENS_NEG    = 4'h3;
  localparam logic [7:0] HDR_CMD     = 8'h01;
  localparam logic [7:0] HDR_CTRL    = 8'h02;

  // control packet sent on a sequence reset
  localparam logic [7:0] CTRL_PKT [HDR_BYTES] = '{8'h02, 8'h00, 8'h00, 8'h01,
                                                  8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [3:0] {
    OP_PANTILT  = 4'd0,
    OP_ZOOM     = 4'd1,
    OP_FOCUS    = 4'd2,
    OP_AUTOFOC  = 4'd3,
    OP_RECALL   = 4'd4,
    OP_STORE    = 4'd5,
    OP_CLEAR    = 4'd6,
    OP_HOME     = 4'd7,
    OP_SEQRESET = 4'd8
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_INV_PAN   = 3'd1,
    REG_INV_TILT  = 3'd2,
    REG_PAN_LIM   = 3'd3,
    REG_TILT_LIM  = 3'd4,
    REG_ZOOM_LIM  = 3'd5,
    REG_FOCUS_LIM = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic       transport_mode;
    logic       invert_pan;
    logic       invert_tilt;
    logic [6:0] pan_speed_limit;
    logic [6:0] tilt_speed_limit;
    logic [3:0] zoom_speed_limit;
    logic [3:0] focus_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic                           is_ctrl;
    logic [PAY_LEN_W-1:0]           len;
    logic [PAY_BYTES-1:0][7:0]      pay;
  } entry_t;

  // saturating negate of a q1.15 value
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) r = 16'sh7fff;
    else                r = -v;
    return r;
  endfunction

  // magnitude of a q1.15 value, one bit wider so that -1.0 fits
  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic [16:0] r;
    if (v[15]) r = 17'(-{v[15], v});
    else       r = {1'b0, v};
    return r;
  endfunction

  // round(mag * limit) with halves away from zero, clamped to 1..limit
  function automatic logic [6:0] speed_code(input logic [16:0] mag,
                                            input logic [6:0]  limit);
    logic [6:0]  lim;
    logic [23:0] prod;
    logic [24:0] sum;
    logic [9:0]  s;
    logic [6:0]  r;
    lim  = (limit == 7'd0) ? 7'd1 : limit;
    prod = 24'(mag) * 24'(lim);
    sum  = {1'b0, prod} + 25'd16384;
    s    = sum[24:15];
    if (s == 10'd0)             r = 7'd1;
    else if (s > {3'b0, lim})   r = lim;
    else                        r = s[6:0];
    return r;
  endfunction

  function automatic logic [7:0] lens_byte(input logic signed [15:0] v,
                                           input logic [3:0] limit);
    logic [6:0] code;
    logic [7:0] r;
    code = speed_code(mag17(v), {3'b0, limit});
    if (v == 16'sd0)  r = BYTE_ZERO;
    else if (v[15])   r = {LENS_NEG, code[3:0]};
    else              r = {LENS_POS, code[3:0]};
    return r;
  endfunction

endpackage

// ===== hdl/vcf_if.sv =====
// valid/ready channel interfaces for commands in and packet bytes out
`timescale 1ns / 1ps
interface vcf_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [15:0] pan_rate;
  logic signed [15:0] tilt_rate;
  logic signed [15:0] lens_rate;
  logic [6:0]         preset_number;
  logic               autofocus_enable;

  modport source (output valid, opcode, pan_rate, tilt_rate, lens_rate, preset_number,
                  autofocus_enable, input ready);
  modport sink (input valid, opcode, pan_rate, tilt_rate, lens_rate, preset_number,
                autofocus_enable, output ready);
endinterface

interface vcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, packet_byte, end_of_packet, input ready);
  modport sink (input valid, packet_byte, end_of_packet, output ready);
endinterface

// ===== hdl/visca_command_framer.sv =====
// top level of the camera command framer: config registers, front, queue, back
// Takes one camera command per item and sends its control packet one byte per
// item on the output, with end_of_packet on the last byte. The back end sends
// one byte every cycle the output is not stalled. A packet has 5 to 9 bytes in
// raw mode, 13 to 17 with the header, 8 for a sequence reset with header;
// without the header a sequence reset sends nothing and retires at once, and
// unknown opcodes are dropped at the input. Commands are classified and
// encoded combinationally and wait in a QUEUE_DEPTH entry queue, so new
// commands are taken while earlier packets are still going out; output byte
// registers keep the two sides apart.
// Config registers must only be written while no packet is pending.
`timescale 1ns / 1ps
module visca_command_framer #(
  parameter int QUEUE_DEPTH = vcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vcf_in_if.sink                         in_chan,
  vcf_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [vcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcf_pkg::*;

  cfg_t   cfg_r;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transport_mode    <= 1'b1;
      cfg_r.invert_pan        <= 1'b0;
      cfg_r.invert_tilt       <= 1'b0;
      cfg_r.pan_speed_limit   <= 7'd24;
      cfg_r.tilt_speed_limit  <= 7'd20;
      cfg_r.zoom_speed_limit  <= 4'd7;
      cfg_r.focus_speed_limit <= 4'd7;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:      cfg_r.transport_mode    <= cfg_data[0];
        REG_INV_PAN:   cfg_r.invert_pan        <= cfg_data[0];
        REG_INV_TILT:  cfg_r.invert_tilt       <= cfg_data[0];
        REG_PAN_LIM:   cfg_r.pan_speed_limit   <= cfg_data[6:0];
        REG_TILT_LIM:  cfg_r.tilt_speed_limit  <= cfg_data[6:0];
        REG_ZOOM_LIM:  cfg_r.zoom_speed_limit  <= cfg_data[3:0];
        REG_FOCUS_LIM: cfg_r.focus_speed_limit <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  vcf_front u_front (
    .cfg              (cfg_r),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .opcode           (in_chan.opcode),
    .pan_rate         (in_chan.pan_rate),
    .tilt_rate        (in_chan.tilt_rate),
    .lens_rate        (in_chan.lens_rate),
    .preset_number    (in_chan.preset_number),
    .autofocus_enable (in_chan.autofocus_enable),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  vcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  vcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .transport_mode (cfg_r.transport_mode),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .packet_byte    (out_chan.packet_byte),
    .end_of_packet  (out_chan.end_of_packet)
  );

endmodule

// ===== hdl/vcf_front.sv =====
// front end: accepts commands, computes speed codes and builds the payload
`timescale 1ns / 1ps
module vcf_front (
  input  vcf_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [3:0]      opcode,
  input  logic signed [15:0] pan_rate,
  input  logic signed [15:0] tilt_rate,
  input  logic signed [15:0] lens_rate,
  input  logic [6:0]      preset_number,
  input  logic            autofocus_enable,
  input  logic            q_full,
  output logic            q_push,
  output vcf_pkg::entry_t q_entry
);
  import vcf_pkg::*;

  logic signed [15:0] pan_v;
  logic signed [15:0] tilt_v;
  logic               known;
  entry_t             e;

  assign in_ready = !q_full;

  always_comb begin
    pan_v  = cfg.invert_pan  ? neg_sat(pan_rate)  : pan_rate;
    tilt_v = cfg.invert_tilt ? neg_sat(tilt_rate) : tilt_rate;
    known  = 1'b1;
    e      = '0;
    e.pay[0] = BYTE_ADDR;
    e.pay[1] = BYTE_CMD;
    case (opcode_t'(opcode))
      OP_PANTILT: begin
        e.pay[2] = CAT_PANTILT;
        e.pay[3] = FN_DRIVE;
        e.pay[4] = {1'b0, speed_code(mag17(pan_v), cfg.pan_speed_limit)};
        e.pay[5] = {1'b0, speed_code(mag17(tilt_v), cfg.tilt_speed_limit)};
        e.pay[6] = pan_v[15] ? DIR_A : ((pan_v != 16'sd0) ? DIR_B : DIR_STOP);
        // tilt directions run the other way round
        e.pay[7] = tilt_v[15] ? DIR_B : ((tilt_v != 16'sd0) ? DIR_A : DIR_STOP);
        e.pay[8] = BYTE_TERM;
        e.len    = PAY_LEN_W'(9);
      end
      OP_ZOOM: begin
        e.pay[2] = CAT_CAMERA;
        e.pay[3] = FN_ZOOM;
        e.pay[4] = lens_byte(lens_rate, cfg.zoom_speed_limit);
        e.pay[5] = BYTE_TERM;
        e.len    = PAY_LEN_W'(6);
      end
      OP_FOCUS: begin
        e.pay[2] = CAT_CAMERA;
        e.pay[3] = FN_FOCUS;
        e.pay[4] = lens_byte(lens_rate, cfg.focus_speed_limit);
        e.pay[5] = BYTE_TERM;
        e.len    = PAY_LEN_W'(6);
      end
      OP_AUTOFOC: begin
        e.pay[2] = CAT_CAMERA;
        e.pay[3] = FN_AF;
        e.pay[4] = autofocus_enable ? AF_ON : AF_OFF;
        e.pay[5] = BYTE_TERM;
        e.len    = PAY_LEN_W'(6);
      end
      OP_RECALL, OP_STORE, OP_CLEAR: begin
        e.pay[2] = CAT_CAMERA;
        e.pay[3] = FN_PRESET;
        e.pay[4] = (opcode_t'(opcode) == OP_RECALL) ? PRE_RECALL :
                   ((opcode_t'(opcode) == OP_STORE) ? PRE_STORE : PRE_CLEAR);
        e.pay[5] = {1'b0, preset_number};
        e.pay[6] = BYTE_TERM;
        e.len    = PAY_LEN_W'(7);
      end
      OP_HOME: begin
        e.pay[2] = CAT_PANTILT;
        e.pay[3] = FN_HOME;
        e.pay[4] = BYTE_TERM;
        e.len    = PAY_LEN_W'(5);
      end
      OP_SEQRESET: begin
        e.is_ctrl = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown opcodes are taken and dropped
  assign q_push  = in_valid && !q_full && known;
  assign q_entry = e;

endmodule

// ===== hdl/vcf_queue.sv =====
// short fifo of built commands between front and back
`timescale 1ns / 1ps
module vcf_queue #(
  parameter int DEPTH = vcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vcf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output vcf_pkg::entry_t head
);
  import vcf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/vcf_back.sv =====
// back end: frames queued commands into header and payload bytes
`timescale 1ns / 1ps
module vcf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            transport_mode,
  input  logic            q_valid,
  input  vcf_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      packet_byte,
  output logic            end_of_packet
);
  import vcf_pkg::*;

  logic [PKT_CNT_W-1:0] idx_r;
  logic [31:0]          seq_r;
  logic                 out_valid_r;
  logic [7:0]           byte_r;
  logic                 eop_r;

  logic [PKT_CNT_W-1:0] total;
  logic [PKT_CNT_W-1:0] hdr_len;
  logic [PAY_IDX_W-1:0] pay_idx;
  logic                 load;
  logic                 fire;
  logic                 emit;
  logic                 last;
  logic [7:0]           cur_byte;

  always_comb begin
    hdr_len = transport_mode ? PKT_CNT_W'(HDR_BYTES) : '0;
    if (q_head.is_ctrl) total = hdr_len;
    else                total = hdr_len + PKT_CNT_W'(q_head.len);
    pay_idx = PAY_IDX_W'(idx_r - hdr_len);
    load    = !out_valid_r || out_ready;
    // a sequence reset in raw mode has no bytes and retires at once
    fire    = q_valid && ((total == '0) || load);
    emit    = q_valid && (total != '0) && load;
    last    = (total == '0) || (idx_r == total - 1'b1);

    if (q_head.is_ctrl) begin
      cur_byte = CTRL_PKT[idx_r[2:0]];
    end else if (transport_mode && (idx_r < PKT_CNT_W'(HDR_BYTES))) begin
      case (idx_r[2:0])
        3'd0:    cur_byte = HDR_CMD;
        3'd3:    cur_byte = {{(8 - PAY_LEN_W){1'b0}}, q_head.len};
        3'd4:    cur_byte = seq_r[31:24];
        3'd5:    cur_byte = seq_r[23:16];
        3'd6:    cur_byte = seq_r[15:8];
        3'd7:    cur_byte = seq_r[7:0];
        default: cur_byte = BYTE_ZERO;
      endcase
    end else if (pay_idx < PAY_IDX_W'(PAY_BYTES)) begin
      cur_byte = q_head.pay[pay_idx];
    end else begin
      cur_byte = BYTE_ZERO;
    end
  end

  assign q_pop = fire && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      seq_r       <= 32'd1;
    end else begin
      if (load) begin
        out_valid_r <= emit;
      end
      if (fire) begin
        if (last) begin
          idx_r <= '0;
          if (q_head.is_ctrl)      seq_r <= 32'd1;
          else if (transport_mode) seq_r <= seq_r + 32'd1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_byte;
      eop_r  <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign packet_byte   = byte_r;
  assign end_of_packet = eop_r;

endmodule

// ===== hdl/vcf_checker.sv =====
// port-level checks on the framer's output packets, bound to the top level
`timescale 1ns / 1ps
module vcf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [7:0]                     out_byte,
  input logic                           out_eop,
  input logic                           cfg_we,
  input logic [vcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [vcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcf_pkg::*;

  logic                 mode_r;
  logic [PKT_CNT_W-1:0] cnt_r;
  logic                 out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      if (cfg_we && (reg_idx_t'(cfg_index) == REG_MODE)) begin
        mode_r <= cfg_data[0];
      end
      if (out_acc) begin
        cnt_r <= out_eop ? '0 : cnt_r + 1'b1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eop))
    else $error("stalled output item changed");

  a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (cnt_r == PKT_CNT_W'(MAX_PKT - 1)) |-> out_eop)
    else $error("packet longer than the longest frame");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (cnt_r == '0) |->
      (mode_r && (out_byte == HDR_CMD || out_byte == HDR_CTRL)) ||
      (!mode_r && out_byte == BYTE_ADDR))
    else $error("bad first byte of packet");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_eop |-> (out_byte == BYTE_TERM) || (mode_r && out_byte == 8'h01))
    else $error("bad last byte of packet");

endmodule

bind visca_command_framer vcf_checker u_vcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.packet_byte),
  .out_eop   (out_chan.end_of_packet),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
